@@ hdl/tmf_pkg.sv @@
// Shared types and constants for the trimmed-mean sample filter.
`default_nettype none
package tmf_pkg;

  // Sample and result width
  localparam int SAMPLE_W = 8;
  // Trim register width
  localparam int TRIM_W   = 4;
  // Quotient bits produced by the divider (the mean never exceeds a sample)
  localparam int QUOT_W   = 8;
  // Quotient bit counter width
  localparam int QBIT_W   = 3;

  // Window sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_SCAN,
    S_DRAIN,
    S_ACC,
    S_DIV,
    S_EMIT
  } tmf_state_t;

endpackage
`default_nettype wire

@@ hdl/tmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/tmf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window mean.
`default_nettype none
module tmf_div
  import tmf_pkg::*;
#(
  parameter int SUM_W = 13,
  parameter int DIV_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output      logic              done,
  output      logic [QUOT_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QBIT_W-1:0] bit_r, bit_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [SUM_W-1:0]  trial;

  // Shifted divisor for the current quotient bit
  assign trial = SUM_W'(divisor) << bit_r;

  // Subtract-and-shift step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = QBIT_W'(QUOT_W - 1);
      rem_nxt  = dividend;
      quot_nxt = '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt        = rem_r - trial;
        quot_nxt[bit_r] = 1'b1;
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
`default_nettype wire

@@ hdl/trimmed_mean_sample_filter_core.sv @@
// Top level of the trimmed-mean sample filter: window store, rank sequencer, divider.
//
// Usage: samples enter on in_valid/in_sample and are held off by in_stall.
// Each beat is written into the window store. The beat that completes a
// window of WINDOW samples starts the evaluation; all other beats are taken
// without a stall and give no result. The evaluation ranks every stored sample
// against every other one with a single shared comparator (stable rank, ties
// broken by arrival order), adds the samples whose rank lies inside the
// trimmed band, then divides the sum by the kept count, one quotient bit a
// cycle. The comparator sweep over the window sets the length of an
// evaluation, and in_stall is high throughout the evaluation.
// The mean appears on out_valid/out_filtered_value and stays until the
// receiver drops out_stall; samples of the next window are taken meanwhile,
// and only the next window's evaluation waits for the output register.
// cfg_we writes trim_count; the value present when a window completes is
// used, saturated to (WINDOW-1)/2. Reset (rst_n low, synchronous) empties
// the window, sets trim_count to 1 and clears out_valid.
`default_nettype none
module trimmed_mean_sample_filter_core
  import tmf_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [TRIM_W-1:0]   cfg_trim_count,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [SAMPLE_W-1:0] out_filtered_value
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int HALF  = (WINDOW - 1) / 2;

  tmf_state_t state_r, state_nxt;

  logic [TRIM_W-1:0]   trim_cfg_r;
  logic [IDX_W-1:0]    fill_r;
  logic [IDX_W-1:0]    i_r;
  logic [IDX_W-1:0]    j_r;
  logic [IDX_W-1:0]    cmp_j_r;
  logic                cmp_v_r;
  logic                key_ld_r;
  logic [SAMPLE_W-1:0] key_r;
  logic [CNT_W-1:0]    rank_r;
  logic [CNT_W-1:0]    lo_r;
  logic [CNT_W-1:0]    hi_r;
  logic [CNT_W-1:0]    kept_r;
  logic [SUM_W-1:0]    sum_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_value_r;

  logic                in_take;
  logic                last_fill;
  logic                out_free;
  logic [IDX_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;
  logic                less;
  logic                sat;
  logic [CNT_W-1:0]    trim_eff;
  logic [SUM_W-1:0]    sum_add;

  assign in_take   = in_valid && !in_stall;
  assign last_fill = (fill_r == IDX_W'(WINDOW - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // Saturate the trim so that at least one sample survives
  assign sat      = (int'({1'b0, trim_cfg_r, 1'b0}) >= WINDOW);
  assign trim_eff = sat ? CNT_W'(HALF) : CNT_W'(trim_cfg_r);

  // Stable ordering: earlier index wins a tie
  assign less = (rd_data < key_r) || ((rd_data == key_r) && (cmp_j_r < i_r));

  // Add the key when its rank falls inside the kept band
  assign sum_add = (rank_r >= lo_r && rank_r < hi_r) ? sum_r + SUM_W'(key_r) : sum_r;

  // Window store
  tmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (in_take),
    .waddr (fill_r),
    .wdata (in_sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Mean divider
  tmf_div #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (kept_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_take && last_fill) state_nxt = S_KEY;
      S_KEY:   state_nxt = S_SCAN;
      S_SCAN:  if (j_r == IDX_W'(WINDOW - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_ACC;
      S_ACC:   state_nxt = (i_r == IDX_W'(WINDOW - 1)) ? S_DIV : S_KEY;
      S_DIV:   if (div_done) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    rd_addr   = j_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_KEY:   rd_addr = i_r;
      S_ACC:   div_start = (i_r == IDX_W'(WINDOW - 1));
      default: rd_addr = j_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trim_cfg_r  <= TRIM_W'(1);
      fill_r      <= '0;
      cmp_v_r     <= 1'b0;
      key_ld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmp_v_r  <= (state_r == S_SCAN);
      key_ld_r <= (state_r == S_KEY);
      if (cfg_we) begin
        trim_cfg_r <= cfg_trim_count;
      end
      // Advance the fill pointer, wrap at the window end
      if (in_take) begin
        fill_r <= last_fill ? '0 : fill_r + 1'b1;
      end
      // Hold the result until the receiver takes it
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ranking and accumulation datapath
  always_ff @(posedge clk) begin
    if (in_take && last_fill) begin
      lo_r   <= trim_eff;
      hi_r   <= CNT_W'(WINDOW) - trim_eff;
      kept_r <= CNT_W'(WINDOW) - (trim_eff << 1);
      sum_r  <= '0;
      i_r    <= '0;
    end
    if (state_r == S_KEY) begin
      rank_r <= '0;
      j_r    <= '0;
    end
    if (state_r == S_SCAN) begin
      j_r <= j_r + 1'b1;
    end
    cmp_j_r <= j_r;
    if (key_ld_r) begin
      key_r <= rd_data;
    end
    if (cmp_v_r && less) begin
      rank_r <= rank_r + 1'b1;
    end
    // Fold the ranked key into the running sum
    if (state_r == S_ACC) begin
      sum_r <= sum_add;
      i_r   <= i_r + 1'b1;
    end
    if (state_r == S_EMIT && out_free) begin
      out_value_r <= div_quot;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the trimmed-mean sample filter core.
`default_nettype none
module tb_top
  import tmf_pkg::*;
();

  localparam int WINDOW        = 20;
  // one window evaluation, plus margin
  localparam int EVAL_CYCLES   = WINDOW * (WINDOW + 3) + 10;
  localparam int SETTLE_CYCLES = EVAL_CYCLES + 40;
  localparam int STUCK_LIMIT   = 20000;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_BEATS   = 125;
  localparam int NUM_ROWS      = 25;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    bit                  mean_known;
    logic [SAMPLE_W-1:0] mean;
    bit                  trim_write;
    logic [TRIM_W-1:0]   trim;
  } dir_row_t;

  // Samples alternate zero and full scale; the reset trim drops one of each,
  // leaving nine of each, so the mean is 2295/18 truncated. The out-of-range
  // trim written before the second window is replaced by the first random
  // phase before that window completes.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFF, 1'b1, 8'd127, 1'b0, 4'h0},
    '{8'h80, 1'b0, 8'h00, 1'b1, 4'hF},
    '{8'h7F, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h01, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'hFE, 1'b0, 8'h00, 1'b0, 4'h0},
    '{8'h55, 1'b0, 8'h00, 1'b0, 4'h0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [TRIM_W-1:0]   cfg_trim_count = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_filtered_value;

  // predictor state: window copy, fill level, live trim setting
  logic [SAMPLE_W-1:0] window_buf [WINDOW];
  int                  fill_cnt = 0;
  logic [TRIM_W-1:0]   trim_reg = 4'd1;
  logic [SAMPLE_W-1:0] mean_queue [$];
  logic [SAMPLE_W-1:0] want_mean;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int stuck_cycles  = 0;
  int win_style     = 0;
  int win_base      = 0;

  trimmed_mean_sample_filter_core #(.WINDOW(WINDOW)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_trim_count    (cfg_trim_count),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered_value(out_filtered_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sort the window copy, drop the trimmed ends, return the truncated mean.
  function automatic logic [SAMPLE_W-1:0] trimmed_mean();
    logic [SAMPLE_W-1:0] ord [WINDOW];
    logic [SAMPLE_W-1:0] key;
    int i, k, t, total;
    ord = window_buf;
    for (i = 1; i < WINDOW; i++) begin
      key = ord[i];
      k = i;
      while (k > 0 && ord[k-1] > key) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = key;
    end
    t = trim_reg;
    if (2 * t >= WINDOW) t = (WINDOW - 1) / 2;
    total = 0;
    for (i = t; i < WINDOW - t; i++) total += ord[i];
    return SAMPLE_W'(total / (WINDOW - 2 * t));
  endfunction

  // Draw one sample in the style chosen for the current window.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int s;
    case (win_style)
      1: begin
        if ($urandom_range(0, 99) < 15) s = $urandom_range(0, 1) ? 255 : 0;
        else s = win_base + $urandom_range(0, 12) - 6;
      end
      2: s = $urandom_range(0, 1) ? 255 : 0;
      3: s = win_base;
      4: s = ($urandom_range(0, 99) < 25) ? $urandom_range(240, 255) : $urandom_range(0, 15);
      default: s = $urandom_range(0, 255);
    endcase
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return SAMPLE_W'(s);
  endfunction

  // Present one beat, hold it through stalls, then fold it into the window copy.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit mean_known,
                             input logic [SAMPLE_W-1:0] mean_typed);
    logic [SAMPLE_W-1:0] mean;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
    window_buf[fill_cnt] = v;
    fill_cnt++;
    if (fill_cnt == WINDOW) begin
      fill_cnt = 0;
      mean = trimmed_mean();
      mean_queue.push_back(mean_known ? mean_typed : mean);
    end
  endtask

  // Drop valid, wait for every pending mean, then let a full evaluation pass.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_trim(input logic [TRIM_W-1:0] v);
    cfg_we         <= 1'b1;
    cfg_trim_count <= v;
    @(posedge clk);
    trim_reg = v;
    cfg_we <= 1'b0;
  endtask

  // Stimulus: reset, directed table, then random phases over trim settings.
  initial begin
    int r, ph, n;
    logic [TRIM_W-1:0] ph_trim;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 75;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].trim_write) begin
        drain_and_settle();
        write_trim(dir_rows[r].trim);
      end
      send_sample(dir_rows[r].sample, dir_rows[r].mean_known, dir_rows[r].mean);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ph_trim = 4'd0;
        1: ph_trim = 4'd15;
        2: ph_trim = 4'd9;
        3: ph_trim = 4'd10;
        4: ph_trim = 4'd1;
        default: ph_trim = TRIM_W'($urandom_range(0, 15));
      endcase
      // pause the sender until the block is idle, then retune the trim
      drain_and_settle();
      write_trim(ph_trim);
      if (ph < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 75;
      end else if (ph < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (fill_cnt == 0) begin
          win_style = $urandom_range(0, 4);
          win_base  = $urandom_range(0, 255);
        end
        send_sample(draw_sample(), 1'b0, '0);
      end
    end

    drain_and_settle();
    if (mean_queue.size() != 0) begin
      if (fail_count < 10) $display("%0d expected means never arrived", mean_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Check each accepted result beat against the oldest pending mean; drive stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mean_queue.size() == 0) begin
        if (fail_count < 10) $display("unexpected result beat: value %0d", out_filtered_value);
        fail_count++;
      end else begin
        want_mean = mean_queue.pop_front();
        if (out_filtered_value !== want_mean) begin
          if (fail_count < 10)
            $display("mean mismatch: expected %0d, got %0d", want_mean, out_filtered_value);
          fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Abort when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
`default_nettype wire
